@@ rtl/core/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared sizes, request and status codes, sequencer states and the
// memory request bundle of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned FillW    = $clog2(Capacity + 1);
  localparam int unsigned CmpW     = ((FillW > PosW) ? FillW : PosW) + 1;

  typedef enum logic [2:0] {
    KindAppend = 3'd0,
    KindRead   = 3'd1,
    KindWrite  = 3'd2,
    KindRemove = 3'd3,
    KindPop    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadIndex = 2'd1,
    StatusEmpty    = 2'd2,
    StatusFull     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StReadWait,
    StShift,
    StResp
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/core/ils_store.sv @@
// ----------------------------------------------------------------------------
// Indexed list store entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_store (
  input  logic                         clk_i,
  input  ils_pkg::mem_req_t            req_i,
  output logic [ils_pkg::DataW-1:0]    rdata_o
);

  logic [ils_pkg::DataW-1:0] mem_q [ils_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

@@ rtl/core/indexed_list_store_unit.sv @@
// ----------------------------------------------------------------------------
// Indexed list store unit
// Bounded ordered list of signed entries with append, read, overwrite,
// remove at index and pop, driven by a small sequencer around one memory.
// ----------------------------------------------------------------------------
// Sequence: after acceptance the execute state leads straight to the result
// state for append, overwrite, bad requests and unused kinds; read and pop
// pass through a read wait state, and remove through one move state per entry
// after the position, one entry moved per cycle. busy_o stays high until the
// result cycle ends; a new item can be taken in the cycle after each result.
// Reset clears the count and the sequencer; entry contents are not cleared.
module indexed_list_store_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [2:0]                        kind_i,
  input  logic [ils_pkg::PosW-1:0]          position_i,
  input  logic signed [ils_pkg::DataW-1:0]  value_i,
  output logic                              done_o,
  output logic signed [ils_pkg::DataW-1:0]  data_o,
  output logic [1:0]                        status_o,
  output logic [ils_pkg::CountW-1:0]        count_o
);

  ils_pkg::state_e                 state_q, state_d;
  logic [ils_pkg::FillW-1:0]       fill_q, fill_d;
  logic [ils_pkg::AddrW-1:0]       idx_q, idx_d;
  logic [2:0]                      kind_q;
  logic [ils_pkg::PosW-1:0]        pos_q;
  logic [ils_pkg::DataW-1:0]       val_q;
  logic [ils_pkg::DataW-1:0]       data_q, data_d;
  ils_pkg::status_e                status_q, status_d;

  ils_pkg::mem_req_t               mem_req;
  logic [ils_pkg::DataW-1:0]       rdata;

  logic                            accept;
  logic                            pos_bad;
  logic                            is_full;
  logic                            is_empty;
  logic                            remove_shift;
  logic                            shift_more;
  logic [ils_pkg::AddrW-1:0]       idx_inc;

  assign accept       = start_i && (state_q == ils_pkg::StIdle);
  assign pos_bad      = ils_pkg::CmpW'(pos_q) >= ils_pkg::CmpW'(fill_q);
  assign is_full      = fill_q == ils_pkg::FillW'(ils_pkg::Capacity);
  assign is_empty     = fill_q == '0;
  assign remove_shift = (ils_pkg::CmpW'(pos_q) + ils_pkg::CmpW'(1))
                        < ils_pkg::CmpW'(fill_q);
  assign idx_inc      = idx_q + ils_pkg::AddrW'(1);
  assign shift_more   = (ils_pkg::FillW'(idx_q) + ils_pkg::FillW'(2)) < fill_q;

  ils_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ils_pkg::StIdle: begin
        if (start_i) begin
          state_d = ils_pkg::StExec;
        end
      end
      ils_pkg::StExec: begin
        state_d = ils_pkg::StResp;
        unique case (kind_q)
          ils_pkg::KindRead: begin
            if (!pos_bad) begin
              state_d = ils_pkg::StReadWait;
            end
          end
          ils_pkg::KindRemove: begin
            if (!pos_bad && remove_shift) begin
              state_d = ils_pkg::StShift;
            end
          end
          ils_pkg::KindPop: begin
            if (!is_empty) begin
              state_d = ils_pkg::StReadWait;
            end
          end
          default: state_d = ils_pkg::StResp;
        endcase
      end
      ils_pkg::StReadWait: state_d = ils_pkg::StResp;
      ils_pkg::StShift: begin
        if (!shift_more) begin
          state_d = ils_pkg::StResp;
        end
      end
      ils_pkg::StResp: state_d = ils_pkg::StIdle;
      default: state_d = ils_pkg::StIdle;
    endcase
  end

  always_comb begin
    fill_d        = fill_q;
    idx_d         = idx_q;
    data_d        = data_q;
    status_d      = status_q;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_q;
    mem_req.wdata = val_q;
    mem_req.re    = 1'b0;
    mem_req.raddr = idx_inc;
    unique case (state_q)
      ils_pkg::StExec: begin
        data_d   = '0;
        status_d = ils_pkg::StatusOk;
        idx_d    = ils_pkg::AddrW'(pos_q);
        unique case (kind_q)
          ils_pkg::KindAppend: begin
            if (is_full) begin
              status_d = ils_pkg::StatusFull;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = ils_pkg::AddrW'(fill_q);
              fill_d        = fill_q + ils_pkg::FillW'(1);
            end
          end
          ils_pkg::KindRead: begin
            if (pos_bad) begin
              status_d = ils_pkg::StatusBadIndex;
              data_d   = '1;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = ils_pkg::AddrW'(pos_q);
            end
          end
          ils_pkg::KindWrite: begin
            if (pos_bad) begin
              status_d = ils_pkg::StatusBadIndex;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = ils_pkg::AddrW'(pos_q);
            end
          end
          ils_pkg::KindRemove: begin
            if (pos_bad) begin
              status_d = ils_pkg::StatusBadIndex;
            end else if (remove_shift) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = ils_pkg::AddrW'(pos_q) + ils_pkg::AddrW'(1);
            end else begin
              fill_d = fill_q - ils_pkg::FillW'(1);
            end
          end
          ils_pkg::KindPop: begin
            if (is_empty) begin
              status_d = ils_pkg::StatusEmpty;
            end else begin
              fill_d        = fill_q - ils_pkg::FillW'(1);
              mem_req.re    = 1'b1;
              mem_req.raddr = ils_pkg::AddrW'(fill_q - ils_pkg::FillW'(1));
            end
          end
          default: status_d = ils_pkg::StatusOk;
        endcase
      end
      ils_pkg::StReadWait: data_d = rdata;
      ils_pkg::StShift: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q;
        mem_req.wdata = rdata;
        idx_d         = idx_inc;
        if (shift_more) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_inc + ils_pkg::AddrW'(1);
        end else begin
          fill_d = fill_q - ils_pkg::FillW'(1);
        end
      end
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ils_pkg::StIdle;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    idx_q    <= idx_d;
    data_q   <= data_d;
    status_q <= status_d;
  end

  assign busy_o   = state_q != ils_pkg::StIdle;
  assign done_o   = state_q == ils_pkg::StResp;
  assign data_o   = data_q;
  assign status_o = status_q;
  assign count_o  = ils_pkg::CountW'(fill_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ils_pkg::FillW'(ils_pkg::Capacity))
    else $error("Entry count exceeds capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("Accepted item did not start the sequencer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("Sequencer did not return to idle after a result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ils_pkg::StShift) |->
      (ils_pkg::FillW'(idx_q) + ils_pkg::FillW'(1)) < fill_q)
    else $error("Entry move ran past the last entry.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ils_pkg::StatusFull) |->
      fill_q == ils_pkg::FillW'(ils_pkg::Capacity))
    else $error("Full status reported on a list that is not full.");

endmodule

@@ dv/indexed_list_store_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list store unit testbench
// Drives append, read, overwrite, remove and pop requests, plus unused
// request codes, through the start/busy handshake in random bursts. It keeps
// its own copy of the list to predict each result and compares every done
// strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module indexed_list_store_unit_tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 80;
  localparam logic [2:0] KindFirstUnused = 3'd5;
  localparam logic [2:0] KindMidUnused = 3'd6;
  localparam logic [2:0] KindLastUnused = 3'd7;
  localparam logic signed [ils_pkg::DataW-1:0] DataMin = 32'sh8000_0000;
  localparam logic signed [ils_pkg::DataW-1:0] DataMax = 32'sh7fff_ffff;
  localparam logic signed [ils_pkg::DataW-1:0] DataAllOnes = -32'sd1;

  typedef struct {
    logic signed [ils_pkg::DataW-1:0] data;
    ils_pkg::status_e                 status;
    logic [ils_pkg::CountW-1:0]       count;
  } list_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start_i;
  logic                             busy_o;
  logic [2:0]                       kind_i;
  logic [ils_pkg::PosW-1:0]         position_i;
  logic signed [ils_pkg::DataW-1:0] value_i;
  logic                             done_o;
  logic signed [ils_pkg::DataW-1:0] data_o;
  logic [1:0]                       status_o;
  logic [ils_pkg::CountW-1:0]       count_o;

  logic signed [ils_pkg::DataW-1:0] list_mem [ils_pkg::Capacity];
  int unsigned                      list_fill;
  list_result_t                     pending_results_q [$];
  int unsigned                      mismatch_count;
  int unsigned                      cycle_count;
  int unsigned                      burst_left;

  indexed_list_store_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_i     (kind_i),
    .position_i (position_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .data_o     (data_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Applies one accepted request to the local list and queues its result.
  task automatic predict_list_request(input logic [2:0] kind,
                                      input logic [ils_pkg::PosW-1:0] pos,
                                      input logic signed [ils_pkg::DataW-1:0] val);
    list_result_t res;
    res.data   = '0;
    res.status = ils_pkg::StatusOk;
    case (kind)
      ils_pkg::KindAppend: begin
        if (list_fill >= ils_pkg::Capacity) begin
          res.status = ils_pkg::StatusFull;
        end else begin
          list_mem[list_fill] = val;
          list_fill++;
        end
      end
      ils_pkg::KindRead: begin
        if (pos >= list_fill) begin
          res.status = ils_pkg::StatusBadIndex;
          res.data   = DataAllOnes;
        end else begin
          res.data = list_mem[pos];
        end
      end
      ils_pkg::KindWrite: begin
        if (pos >= list_fill) res.status = ils_pkg::StatusBadIndex;
        else list_mem[pos] = val;
      end
      ils_pkg::KindRemove: begin
        if (pos >= list_fill) begin
          res.status = ils_pkg::StatusBadIndex;
        end else begin
          for (int unsigned i = pos; i + 1 < list_fill; i++) list_mem[i] = list_mem[i + 1];
          list_fill--;
        end
      end
      ils_pkg::KindPop: begin
        if (list_fill == 0) begin
          res.status = ils_pkg::StatusEmpty;
        end else begin
          list_fill--;
          res.data = list_mem[list_fill];
        end
      end
      default: begin
      end
    endcase
    res.count = list_fill[ils_pkg::CountW-1:0];
    pending_results_q.push_back(res);
  endtask

  // Sends one item in the current burst, opening a new burst after a random gap.
  task automatic send_item(input logic [2:0] kind, input logic [ils_pkg::PosW-1:0] pos,
                           input logic signed [ils_pkg::DataW-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(7, 1);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
    end
    burst_left--;
    kind_i     <= kind;
    position_i <= pos;
    value_i    <= val;
    start_i    <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_list_request(kind, pos, val);
  endtask

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: data %0d status %0d count %0d",
                                  data_o, status_o, count_o));
      end else begin
        want = pending_results_q.pop_front();
        if (data_o !== want.data)
          report_mismatch($sformatf("data %0d, predicted %0d", data_o, want.data));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status_o, want.status));
        if (count_o !== want.count)
          report_mismatch($sformatf("count %0d, predicted %0d", count_o, want.count));
      end
    end
  end

  function automatic logic signed [ils_pkg::DataW-1:0] pick_value();
    case ($urandom_range(9, 0))
      0: return DataMin;
      1: return DataMax;
      2: return DataAllOnes;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a valid index, sometimes the edges of the list, sometimes anything.
  function automatic logic [ils_pkg::PosW-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (list_fill == 0 || r < 15)
      return ils_pkg::PosW'($urandom_range(ils_pkg::Capacity - 1, 0));
    if (r < 22) return ils_pkg::PosW'(list_fill - 1);
    if (r < 27) return '0;
    if (r < 32 && list_fill < ils_pkg::Capacity) return ils_pkg::PosW'(list_fill);
    return ils_pkg::PosW'($urandom_range(list_fill - 1, 0));
  endfunction

  task automatic send_random_request(input int unsigned append_pct,
                                     input int unsigned shrink_pct);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 3) begin
      send_item(3'($urandom_range(KindLastUnused, KindFirstUnused)),
                ils_pkg::PosW'($urandom), $urandom);
    end else if (r < 3 + append_pct) begin
      send_item(ils_pkg::KindAppend, ils_pkg::PosW'($urandom), pick_value());
    end else if (r < 3 + append_pct + shrink_pct) begin
      if ($urandom_range(1, 0) == 0) send_item(ils_pkg::KindRemove, pick_position(), $urandom);
      else send_item(ils_pkg::KindPop, ils_pkg::PosW'($urandom), $urandom);
    end else if ($urandom_range(1, 0) == 0) begin
      send_item(ils_pkg::KindRead, pick_position(), $urandom);
    end else begin
      send_item(ils_pkg::KindWrite, pick_position(), pick_value());
    end
  endtask

  task automatic test_empty_list();
    send_item(ils_pkg::KindPop, '1, DataAllOnes);
    send_item(ils_pkg::KindRead, '0, '0);
    send_item(ils_pkg::KindWrite, '1, DataMax);
    send_item(ils_pkg::KindRemove, '0, DataMin);
    send_item(ils_pkg::KindAppend, '0, DataMin);
    send_item(ils_pkg::KindAppend, '1, DataMax);
    send_item(ils_pkg::KindRead, 6'd0, '0);
    send_item(ils_pkg::KindRead, 6'd1, '0);
    send_item(ils_pkg::KindRead, 6'd2, '0);
    send_item(ils_pkg::KindWrite, 6'd1, DataAllOnes);
    send_item(ils_pkg::KindRemove, 6'd0, '0);
    send_item(ils_pkg::KindPop, '0, '0);
    send_item(ils_pkg::KindPop, '0, '0);
  endtask

  task automatic test_unused_kinds();
    send_item(KindFirstUnused, '1, DataAllOnes);
    send_item(ils_pkg::KindAppend, '0, 32'sd17);
    send_item(KindMidUnused, '0, DataMin);
    send_item(KindLastUnused, '0, DataMax);
  endtask

  task automatic test_index_edges();
    send_item(ils_pkg::KindAppend, '0, 32'sd100);
    send_item(ils_pkg::KindAppend, '0, -32'sd200);
    send_item(ils_pkg::KindRead, 6'd2, '0);
    send_item(ils_pkg::KindRead, 6'd3, '0);
    send_item(ils_pkg::KindRead, '1, '0);
    send_item(ils_pkg::KindRemove, 6'd1, '0);
    send_item(ils_pkg::KindRemove, 6'd1, '0);
    send_item(ils_pkg::KindRead, 6'd0, '0);
  endtask

  // Fills the list to capacity, then hits the full-list and far-index cases.
  task automatic test_fill_to_capacity();
    while (list_fill < ils_pkg::Capacity) send_random_request(75, 8);
    repeat (3) send_item(ils_pkg::KindAppend, ils_pkg::PosW'($urandom), pick_value());
    send_item(ils_pkg::KindRead, '1, '0);
    send_item(ils_pkg::KindWrite, '1, pick_value());
    send_item(ils_pkg::KindRead, '1, '0);
    send_item(ils_pkg::KindRemove, '0, '0);
    send_item(ils_pkg::KindAppend, '0, pick_value());
    send_item(ils_pkg::KindRemove, '0, '0);
    send_item(ils_pkg::KindPop, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned append_pct,
                                     input int unsigned shrink_pct);
    repeat (n_items) send_random_request(append_pct, shrink_pct);
  endtask

  task automatic test_drain_list();
    while (list_fill > 0) send_item(ils_pkg::KindPop, ils_pkg::PosW'($urandom), $urandom);
    send_item(ils_pkg::KindPop, ils_pkg::PosW'($urandom), $urandom);
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    kind_i         = ils_pkg::KindAppend;
    position_i     = '0;
    value_i        = '0;
    list_fill      = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_unused_kinds();
    test_index_edges();
    test_fill_to_capacity();
    repeat (2) begin
      test_random_traffic(50, 15, 60);
      test_random_traffic(50, 70, 15);
      test_random_traffic(30, 35, 35);
    end
    test_drain_list();

    start_i <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ indexed_list_store_unit.f @@
rtl/core/ils_pkg.sv
rtl/core/ils_store.sv
rtl/core/indexed_list_store_unit.sv
dv/indexed_list_store_unit_tb.sv
